// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, status codes and the flag group that travels with each
// classified item from the front part to the back part.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Operation codes; codes six and seven behave as reduce.
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_NEG = 3'd4;
  localparam logic [2:0] FN_RED = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Flags of one classified item.
  typedef struct packed {
    logic [1:0] status;   // status when the result is known early
    logic       direct;   // result is 0/1 with status, no reduction needed
    logic       num_neg;  // numerator sign
    logic       den_neg;  // denominator sign
  } rau_flags_t;

endpackage

// ===== rtl/rau_front.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic front end
// Accepts an item, splits operands into sign and magnitude, forms the cross
// products on one shared multiplier and pushes the raw fraction to the queue.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_func,
  input  logic signed [31:0]  in_a_num,
  input  logic signed [31:0]  in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic signed [31:0]  in_b_den,
  input  logic                q_full,
  output logic                q_push,
  output rau_flags_t          q_flags,
  output logic [2*W-1:0]      q_num,
  output logic [2*W-1:0]      q_den
);

  localparam int PW = 2 * W;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    step_r;
  logic [2:0]    func_r;
  logic          zerr_r;
  logic          an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r;
  logic [W-1:0]  an_mag_r, ad_mag_r, bn_mag_r, bd_mag_r;
  logic [PW-1:0] p0_r, p1_r, p2_r;

  logic [W-1:0]  an_x, ad_x, bn_x, bd_x;
  logic [W-1:0]  an_m, ad_m, bn_m, bd_m;
  logic          uses_b, zerr;
  logic          accept;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic          pa_neg, pb_neg, sum_neg;
  logic [PW-1:0] sum_mag;

  // Operand split: low W bits as two's complement, magnitude of W bits.
  assign an_x = in_a_num[W-1:0];
  assign ad_x = in_a_den[W-1:0];
  assign bn_x = in_b_num[W-1:0];
  assign bd_x = in_b_den[W-1:0];
  assign an_m = an_x[W-1] ? (~an_x + 1'b1) : an_x;
  assign ad_m = ad_x[W-1] ? (~ad_x + 1'b1) : ad_x;
  assign bn_m = bn_x[W-1] ? (~bn_x + 1'b1) : bn_x;
  assign bd_m = bd_x[W-1] ? (~bd_x + 1'b1) : bd_x;

  // Zero denominator or zero divisor check.
  assign uses_b = (in_func <= FN_DIV);
  assign zerr   = (ad_m == '0) || (uses_b && (bd_m == '0)) ||
                  ((in_func == FN_DIV) && (bn_m == '0));

  assign accept = start && (state_r == F_IDLE);
  assign busy   = (state_r != F_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          state_nxt = (zerr || (in_func > FN_DIV)) ? F_PUSH : F_MUL;
        end
      end
      F_MUL: begin
        if (step_r == 2'd2) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (accept || (state_r != F_MUL)) begin
        step_r <= 2'd0;
      end else begin
        step_r <= step_r + 2'd1;
      end
    end
  end

  // Operand capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      zerr_r   <= zerr;
      an_neg_r <= an_x[W-1];
      ad_neg_r <= ad_x[W-1];
      bn_neg_r <= bn_x[W-1];
      bd_neg_r <= bd_x[W-1];
      an_mag_r <= an_m;
      ad_mag_r <= ad_m;
      bn_mag_r <= bn_m;
      bd_mag_r <= bd_m;
    end
  end

  // Shared multiplier, one product per cycle.
  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = an_mag_r;
        mul_b = (func_r == FN_MUL) ? bn_mag_r : bd_mag_r;
      end
      2'd1: begin
        mul_a = ad_mag_r;
        mul_b = bn_mag_r;
      end
      default: begin
        mul_a = ad_mag_r;
        mul_b = (func_r == FN_DIV) ? bn_mag_r : bd_mag_r;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (state_r == F_MUL) begin
      case (step_r)
        2'd0:    p0_r <= prod;
        2'd1:    p1_r <= prod;
        default: p2_r <= prod;
      endcase
    end
  end

  // Signed sum of the two cross products for add and subtract.
  always_comb begin
    pa_neg = an_neg_r ^ bd_neg_r;
    pb_neg = ad_neg_r ^ bn_neg_r ^ (func_r == FN_SUB);
    if (pa_neg == pb_neg) begin
      sum_mag = p0_r + p1_r;
      sum_neg = pa_neg;
    end else if (p0_r >= p1_r) begin
      sum_mag = p0_r - p1_r;
      sum_neg = pa_neg;
    end else begin
      sum_mag = p1_r - p0_r;
      sum_neg = pb_neg;
    end
  end

  // Raw fraction and classification.
  always_comb begin
    q_flags = '0;
    case (func_r) inside
      FN_ADD, FN_SUB: begin
        q_num           = sum_mag;
        q_flags.num_neg = sum_neg;
        q_den           = p2_r;
        q_flags.den_neg = ad_neg_r ^ bd_neg_r;
      end
      FN_MUL: begin
        q_num           = p0_r;
        q_flags.num_neg = an_neg_r ^ bn_neg_r;
        q_den           = p2_r;
        q_flags.den_neg = ad_neg_r ^ bd_neg_r;
      end
      FN_DIV: begin
        q_num           = p0_r;
        q_flags.num_neg = an_neg_r ^ bd_neg_r;
        q_den           = p2_r;
        q_flags.den_neg = ad_neg_r ^ bn_neg_r;
      end
      FN_NEG: begin
        q_num           = PW'(an_mag_r);
        q_flags.num_neg = !an_neg_r;
        q_den           = PW'(ad_mag_r);
        q_flags.den_neg = ad_neg_r;
      end
      default: begin
        q_num           = PW'(an_mag_r);
        q_flags.num_neg = an_neg_r;
        q_den           = PW'(ad_mag_r);
        q_flags.den_neg = ad_neg_r;
      end
    endcase
    q_flags.direct = zerr_r || (q_num == '0);
    q_flags.status = zerr_r ? ST_ZERO : ST_OK;
  end

  assign q_push = (state_r == F_PUSH) && !q_full;

endmodule

// ===== rtl/rau_queue.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic item queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module rau_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/rau_back.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic back end
// Reduces each raw fraction not flagged direct by binary GCD, divides both parts
// by the GCD with two restoring dividers in step, range checks and drives the result.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  rau_flags_t          q_flags,
  input  logic [2*W-1:0]      q_num,
  input  logic [2*W-1:0]      q_den,
  output logic                out_valid,
  output logic signed [31:0]  out_res_num,
  output logic signed [31:0]  out_res_den,
  output logic [1:0]          out_status
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW);
  localparam logic [PW-1:0] LIMIT = PW'((64'(1) << (W - 1)) - 64'(1));

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_ALIGN = 3'd1;
  localparam logic [2:0] B_GCD   = 3'd2;
  localparam logic [2:0] B_DIV   = 3'd3;
  localparam logic [2:0] B_FIN   = 3'd4;

  logic [2:0]    state_r;
  logic [PW-1:0] u_r, v_r;
  logic [PW-1:0] nq_r, dq_r;
  logic [PW-1:0] nrem_r, drem_r;
  logic [PW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          num_neg_r, den_neg_r;

  logic          out_valid_r;
  logic [31:0]   out_num_r, out_den_r;
  logic [1:0]    out_status_r;

  logic [PW:0]   nrem_sh, drem_sh;
  logic          nbit, dbit;
  logic [PW-1:0] nrem_nxt, drem_nxt;
  logic [W-1:0]  num_val, den_val;

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  // One restoring division step on both quotients.
  always_comb begin
    nrem_sh  = {nrem_r, nq_r[PW-1]};
    drem_sh  = {drem_r, dq_r[PW-1]};
    nbit     = (nrem_sh >= {1'b0, div_r});
    dbit     = (drem_sh >= {1'b0, div_r});
    nrem_nxt = nbit ? PW'(nrem_sh - {1'b0, div_r}) : PW'(nrem_sh);
    drem_nxt = dbit ? PW'(drem_sh - {1'b0, div_r}) : PW'(drem_sh);
  end

  // Signed result fields from the reduced magnitudes.
  assign num_val = num_neg_r ? (~nq_r[W-1:0] + 1'b1) : nq_r[W-1:0];
  assign den_val = den_neg_r ? (~dq_r[W-1:0] + 1'b1) : dq_r[W-1:0];

  // Reduction sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            if (q_flags.direct) begin
              out_valid_r <= 1'b1;
            end else begin
              state_r <= B_ALIGN;
            end
          end
        end
        B_ALIGN: begin
          if (u_r[0] || v_r[0]) begin
            state_r <= B_GCD;
          end
        end
        B_GCD: begin
          if (u_r == '0) begin
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          if (cnt_r == CW'(PW - 1)) begin
            state_r <= B_FIN;
          end
        end
        B_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Datapath: common factors of two come off both parts, the odd GCD
  // is found by subtraction, then both parts are divided by it.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        u_r       <= q_num;
        v_r       <= q_den;
        nq_r      <= q_num;
        dq_r      <= q_den;
        num_neg_r <= q_flags.num_neg;
        den_neg_r <= q_flags.den_neg;
        if (!q_empty && q_flags.direct) begin
          out_num_r    <= 32'd0;
          out_den_r    <= 32'd1;
          out_status_r <= q_flags.status;
        end
      end
      B_ALIGN: begin
        if (!(u_r[0] || v_r[0])) begin
          u_r  <= u_r >> 1;
          v_r  <= v_r >> 1;
          nq_r <= nq_r >> 1;
          dq_r <= dq_r >> 1;
        end
      end
      B_GCD: begin
        nrem_r <= '0;
        drem_r <= '0;
        cnt_r  <= '0;
        div_r  <= v_r;
        if (u_r != '0) begin
          if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r >= v_r) begin
            u_r <= u_r - v_r;
          end else begin
            v_r <= v_r - u_r;
          end
        end
      end
      B_DIV: begin
        nrem_r <= nrem_nxt;
        drem_r <= drem_nxt;
        nq_r   <= {nq_r[PW-2:0], nbit};
        dq_r   <= {dq_r[PW-2:0], dbit};
        cnt_r  <= cnt_r + 1'b1;
      end
      B_FIN: begin
        if ((nq_r > LIMIT) || (dq_r > LIMIT)) begin
          out_num_r    <= 32'd0;
          out_den_r    <= 32'd1;
          out_status_r <= ST_RANGE;
        end else begin
          out_num_r    <= 32'(signed'(num_val));
          out_den_r    <= 32'(signed'(den_val));
          out_status_r <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_status  = out_status_r;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides, negates or reduces fractions and
// returns the result reduced by its GCD, with a status code.
//
//   Channel   Ports                                    Handshake
//   input     in_func, in_a_num, in_a_den,             start high, busy low
//             in_b_num, in_b_den
//   result    out_res_num, out_res_den, out_status     out_valid for one cycle
//
// The front part forms up to three products per item on one shared
// multiplier; a two-entry queue lets it take the next item meanwhile.
// The back part sets the rate and pops an item only when idle: alignment
// and binary GCD steps, then 2*VALUE_BITS division steps; items that fail
// the zero check or have a zero numerator skip the reduction.
// Reset is synchronous and active low. Results cannot be stalled.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_func,
  input  logic signed [31:0]  in_a_num,
  input  logic signed [31:0]  in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic signed [31:0]  in_b_den,
  output logic                out_valid,
  output logic signed [31:0]  out_res_num,
  output logic signed [31:0]  out_res_den,
  output logic [1:0]          out_status
);

  localparam int PW = 2 * VALUE_BITS;
  localparam int DW = $bits(rau_flags_t) + 2 * PW;

  logic          q_push, q_full, q_pop, q_empty;
  rau_flags_t    f_flags, b_flags;
  logic [PW-1:0] f_num, f_den, b_num, b_den;
  logic [DW-1:0] q_out;

  // Accept, classify and multiply.
  rau_front #(.W(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_func  (in_func),
    .in_a_num (in_a_num),
    .in_a_den (in_a_den),
    .in_b_num (in_b_num),
    .in_b_den (in_b_den),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_flags  (f_flags),
    .q_num    (f_num),
    .q_den    (f_den)
  );

  // Queue of classified items.
  rau_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_flags, f_num, f_den}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign {b_flags, b_num, b_den} = q_out;

  // Reduce and deliver.
  rau_back #(.W(VALUE_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_flags     (b_flags),
    .q_num       (b_num),
    .q_den       (b_den),
    .out_valid   (out_valid),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_status  (out_status)
  );

endmodule

// ===== rtl/rau_checker.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level properties of the result channel and the start handshake.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_res_num,
  input logic signed [31:0] out_res_den,
  input logic [1:0]         out_status
);

  // Status is one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_ZERO ||
                   out_status == ST_RANGE))
    else $error("undefined status code");

  // Any error gives the fraction 0/1.
  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_res_num == 0 && out_res_den == 1))
    else $error("error result is not 0/1");

  // A zero numerator comes with a denominator of one.
  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res_num == 0) |-> (out_res_den == 1))
    else $error("zero numerator without unit denominator");

  // A good result never has a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> (out_res_den != 0))
    else $error("zero denominator in result");

  // An accepted item makes the front end busy in the following cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// ===== test/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Sends fraction pairs with every operation code, works out the reduced
// result of each item on the side and checks every result strobe against it.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  // One input item and one result item.
  typedef struct {
    logic [2:0]  func;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } frac_item_t;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic [1:0]  status;
  } frac_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_func = '0;
  logic signed [31:0] in_a_num = '0;
  logic signed [31:0] in_a_den = '0;
  logic signed [31:0] in_b_num = '0;
  logic signed [31:0] in_b_den = '0;
  logic        out_valid;
  logic signed [31:0] out_res_num;
  logic signed [31:0] out_res_den;
  logic [1:0]  out_status;

  frac_item_t   pending_items[$];
  frac_result_t expected_fracs[$];
  int  mismatch_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  bit  drain_request = 1'b0;
  bit  stimulus_done = 1'b0;
  bit  in_taken = 1'b0;

  rational_arithmetic_unit #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den), .out_valid(out_valid),
    .out_res_num(out_res_num), .out_res_den(out_res_den), .out_status(out_status)
  );

  always #4 clk = ~clk;

  // Signed operand as sign and magnitude, with upper bits dropped.
  function automatic logic [64:0] to_sign_mag(logic [31:0] raw);
    logic [63:0] x;
    logic        neg;
    x = 64'(raw[VALUE_BITS-1:0]);
    neg = x[VALUE_BITS-1];
    return {neg, neg ? ((64'd1 << VALUE_BITS) - x) : x};
  endfunction

  function automatic logic [64:0] sm_times(logic [64:0] a, logic [64:0] b);
    logic [63:0] m;
    m = a[63:0] * b[63:0];
    return {(m != 0) && (a[64] != b[64]), m};
  endfunction

  function automatic logic [64:0] sm_plus(logic [64:0] a, logic [64:0] b);
    logic [64:0] r;
    if (a[64] == b[64]) r = {a[64], a[63:0] + b[63:0]};
    else if (a[63:0] >= b[63:0]) r = {a[64], a[63:0] - b[63:0]};
    else r = {b[64], b[63:0] - a[63:0]};
    if (r[63:0] == 0) r[64] = 1'b0;
    return r;
  endfunction

  function automatic logic [64:0] sm_negate(logic [64:0] a);
    if (a[63:0] != 0) a[64] = ~a[64];
    return a;
  endfunction

  // Expected reduced fraction and status of one item.
  function automatic frac_result_t reduce_fraction(frac_item_t it);
    logic [64:0] an, ad, bn, bd, num, den;
    logic [63:0] x, y, t, limit;
    frac_result_t r;
    bit uses_b;
    an = to_sign_mag(it.a_num);
    ad = to_sign_mag(it.a_den);
    bn = to_sign_mag(it.b_num);
    bd = to_sign_mag(it.b_den);
    uses_b = it.func <= FN_DIV;
    limit = (64'd1 << (VALUE_BITS - 1)) - 1;
    r.num = 0;
    r.den = 1;
    r.status = ST_OK;
    if (ad[63:0] == 0 || (uses_b && bd[63:0] == 0) ||
        (it.func == FN_DIV && bn[63:0] == 0)) begin
      r.status = ST_ZERO;
      return r;
    end
    case (it.func)
      FN_ADD: begin
        num = sm_plus(sm_times(an, bd), sm_times(ad, bn));
        den = sm_times(ad, bd);
      end
      FN_SUB: begin
        num = sm_plus(sm_times(an, bd), sm_negate(sm_times(ad, bn)));
        den = sm_times(ad, bd);
      end
      FN_MUL: begin
        num = sm_times(an, bn);
        den = sm_times(ad, bd);
      end
      FN_DIV: begin
        num = sm_times(an, bd);
        den = sm_times(ad, bn);
      end
      FN_NEG: begin
        num = sm_negate(an);
        den = ad;
      end
      default: begin
        num = an;
        den = ad;
      end
    endcase
    if (num[63:0] == 0) return r;
    x = num[63:0];
    y = den[63:0];
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    num[63:0] = num[63:0] / x;
    den[63:0] = den[63:0] / x;
    if (num[63:0] > limit || den[63:0] > limit) begin
      r.status = ST_RANGE;
      return r;
    end
    r.num = num[64] ? 32'(-num[63:0]) : num[31:0];
    r.den = den[64] ? 32'(-den[63:0]) : den[31:0];
    return r;
  endfunction

  // Operand with a bias toward small values, extremes and zero.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'($urandom_range(0, 2));
      3, 4:    return $urandom;
      5:       return 32'($urandom_range(0, 65535)) * 32'($urandom_range(1, 3000));
      default: return $urandom_range(0, 1) ? 32'($urandom_range(1, 1000))
                                           : -32'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic queue_item(logic [2:0] f, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
    frac_item_t it;
    it.func = f;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    pending_items.push_back(it);
  endtask

  // Stimulus: directed corner cases, then random items with a drain pause.
  initial begin
    logic [2:0] f;
    for (int k = 0; k < 8; k++) begin
      f = 3'(k);
      queue_item(f, 32'd6, -32'd8, 32'd3, 32'd4);
    end
    queue_item(FN_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    queue_item(FN_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
    queue_item(FN_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    queue_item(FN_RED, 32'h8000_0000, 32'd2, 32'd0, 32'd0);
    queue_item(FN_NEG, 32'h8000_0000, 32'h8000_0000, 32'd5, 32'd0);
    queue_item(FN_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    queue_item(FN_SUB, 32'd1, 32'd1, 32'd1, 32'd0);
    queue_item(FN_DIV, 32'd3, 32'd5, 32'd0, 32'd7);
    queue_item(FN_NEG, 32'd3, 32'd0, 32'd1, 32'd1);
    queue_item(FN_SUB, 32'd5, 32'd7, 32'd5, 32'd7);
    queue_item(FN_RED, 32'd0, -32'd9, 32'd0, 32'd0);
    queue_item(FN_DIV, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001);
    queue_item(FN_MUL, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffd, 32'h7fff_ffff);
    queue_item(FN_ADD, 32'h5555_5555, 32'haaaa_aaab, 32'haaaa_aaaa, 32'h5555_5555);
    queue_item(FN_RED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    for (int k = 0; k < 700; k++) begin
      if (k == 350) begin
        wait (pending_items.size() == 0);
        drain_request = 1'b1;
        wait (drain_request == 1'b0);
      end
      queue_item(3'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                 pick_operand(), pick_operand());
    end
    stimulus_done = 1'b1;
  end

  // Driver: bursts with random gaps, one pause that drains all results.
  // An item stays on the inputs until the rising edge that accepts it.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !in_taken) begin
      start <= 1'b1;
    end else if (drain_request) begin
      start <= 1'b0;
      if (expected_fracs.size() == 0) drain_request <= 1'b0;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_items.size() > 0) begin
      in_func <= pending_items[0].func;
      in_a_num <= pending_items[0].a_num;
      in_a_den <= pending_items[0].a_den;
      in_b_num <= pending_items[0].b_num;
      in_b_den <= pending_items[0].b_den;
      start <= 1'b1;
      void'(pending_items.pop_front());
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(0, 12);
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: take accepted items and compare result strobes in order.
  always @(posedge clk) begin
    frac_result_t exp_r;
    if (rst_n) begin
      in_taken <= start && !busy;
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        expected_fracs.push_back(reduce_fraction('{in_func, in_a_num, in_a_den,
                                                   in_b_num, in_b_den}));
        items_sent <= items_sent + 1;
      end
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (expected_fracs.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("Unexpected result %0d/%0d status %0d",
                                            out_res_num, out_res_den, out_status);
        end else begin
          exp_r = expected_fracs.pop_front();
          if (out_res_num !== exp_r.num || out_res_den !== exp_r.den ||
              out_status !== exp_r.status) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("Mismatch: got %0d/%0d st %0d, expected %0d/%0d st %0d",
                       out_res_num, out_res_den, out_status, $signed(exp_r.num),
                       $signed(exp_r.den), exp_r.status);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_fracs.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Reset, then wait for the end of stimulus and the last result.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && pending_items.size() == 0);
    @(posedge clk);
    while (start || expected_fracs.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d items over all operation codes, %0d results checked.",
             items_sent, results_seen);
    if (mismatch_count == 0 && expected_fracs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
